// ===== rtl/gamepad_input_conditioner_unit_macros.svh =====
// Assertion macros shared by the gamepad input conditioner RTL.
`ifndef GAMEPAD_INPUT_CONDITIONER_UNIT_MACROS_SVH
`define GAMEPAD_INPUT_CONDITIONER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define GIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gic assertion failed");
// Next-cycle implication, disabled while in reset.
`define GIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gic assertion failed");
`else
`define GIC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GIC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gic_pkg.sv =====
// Types and constants for the gamepad input conditioner.
`default_nettype none
package gic_pkg;

    localparam int BTN_W   = 16;
    localparam int AXIS_W  = 16;
    localparam int FILT_W  = 24;   // 16.8 filter state
    localparam int FRAC_W  = 8;
    localparam int ALPHA_W = 16;
    localparam int TIMER_W = 16;
    localparam int AMT_W   = 8;
    localparam int NUM_AXES = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_TIMEOUT = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'd9362;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd60;

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_LAST   = 2'd3
    } quad_t;

    typedef struct packed {
        logic                      connected;
        logic [BTN_W-1:0]          buttons;
        logic signed [AXIS_W-1:0]  left_x;
        logic signed [AXIS_W-1:0]  left_y;
        logic signed [AXIS_W-1:0]  right_x;
        logic signed [AXIS_W-1:0]  right_y;
        logic                      set_left_rumble;
        logic [AMT_W-1:0]          left_amount;
        logic [TIMER_W-1:0]        left_ticks;
        logic                      set_right_rumble;
        logic [AMT_W-1:0]          right_amount;
        logic [TIMER_W-1:0]        right_ticks;
    } item_t;

    typedef struct packed {
        logic [BTN_W-1:0]          buttons_pressed;
        logic [BTN_W-1:0]          buttons_released;
        logic signed [AXIS_W-1:0]  smooth_left_x;
        logic signed [AXIS_W-1:0]  smooth_left_y;
        logic signed [AXIS_W-1:0]  smooth_right_x;
        logic signed [AXIS_W-1:0]  smooth_right_y;
        logic                      rotation_done;
        logic [AMT_W-1:0]          left_motor;
        logic [AMT_W-1:0]          right_motor;
        logic                      link_up;
    } result_t;

    // Results of the button, gesture and rumble logic for one tick.
    typedef struct packed {
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] released;
        logic             rotation_done;
        logic [AMT_W-1:0] left_motor;
        logic [AMT_W-1:0] right_motor;
    } ctrl_res_t;

endpackage
`default_nettype wire

// ===== rtl/gic_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface gic_in_if;
    import gic_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gic_out_if;
    import gic_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gic_axis_lane.sv =====
// One low-pass filter lane: 16.8 state, f += round(alpha*(x*256 - f) / 65536).
`default_nettype none
module gic_axis_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic [gic_pkg::ALPHA_W-1:0]        alpha,
    input  wire logic signed [gic_pkg::AXIS_W-1:0]  sample,
    output logic signed [gic_pkg::AXIS_W-1:0]       smooth
);
    import gic_pkg::*;

    logic signed [FILT_W-1:0]             filt_reg;
    logic signed [FILT_W-1:0]             filt_next;
    logic signed [FILT_W:0]               diff;
    logic signed [ALPHA_W:0]              alpha_s;
    logic signed [FILT_W+ALPHA_W+1:0]     prod;
    logic signed [FILT_W+ALPHA_W+1:0]     prod_rnd;
    logic signed [FILT_W+1:0]             delta;
    logic signed [FILT_W+1:0]             filt_sum;
    logic signed [FILT_W-1:0]             filt_new;

    always_comb
    begin
        diff     = (FILT_W+1)'($signed({sample, {FRAC_W{1'b0}}})) - (FILT_W+1)'(filt_reg);
        alpha_s  = $signed({1'b0, alpha});
        prod     = diff * alpha_s;
        // add one half, then floor through the arithmetic shift
        prod_rnd = prod + (FILT_W+ALPHA_W+2)'(32768);
        delta    = prod_rnd[FILT_W+ALPHA_W+1:ALPHA_W];
        filt_sum = (FILT_W+2)'(filt_reg) + delta;
        filt_new = filt_sum[FILT_W-1:0];   // stays between old f and x*256
        filt_next = step ? filt_new : filt_reg;
        smooth   = filt_next[FILT_W-1:FRAC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else
        begin
            filt_reg <= filt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gic_tick_ctrl.sv =====
// Button edges, rotation gesture tracker and rumble countdowns.
`default_nettype none
`include "gamepad_input_conditioner_unit_macros.svh"
module gic_tick_ctrl #(
    parameter int BUTTON_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire gic_pkg::item_t              item,
    input  wire logic [gic_pkg::TIMER_W-1:0] rotation_timeout,
    output gic_pkg::ctrl_res_t               res
);
    import gic_pkg::*;

    localparam int USED_BITS = (BUTTON_BITS < BTN_W) ? BUTTON_BITS : BTN_W;

    logic [USED_BITS-1:0] held_reg,   held_next;
    quad_t                quad_reg,   quad_next;
    logic [TIMER_W-1:0]   timer_reg,  timer_next;
    logic [AMT_W-1:0]     lstr_reg,   lstr_next;
    logic [TIMER_W-1:0]   lcnt_reg,   lcnt_next;
    logic [AMT_W-1:0]     rstr_reg,   rstr_next;
    logic [TIMER_W-1:0]   rcnt_reg,   rcnt_next;

    logic                 conn;
    logic [USED_BITS-1:0] btn;
    logic                 lx_pos, lx_neg, ly_pos, ly_neg;
    quad_t                quad_t0;
    logic [TIMER_W-1:0]   timer_t0;

    always_comb
    begin
        conn   = item.connected;
        btn    = item.buttons[USED_BITS-1:0];
        lx_pos = !item.left_x[AXIS_W-1] && (item.left_x != '0);
        lx_neg = item.left_x[AXIS_W-1];
        ly_pos = !item.left_y[AXIS_W-1] && (item.left_y != '0);
        ly_neg = item.left_y[AXIS_W-1];

        held_next  = held_reg;
        quad_next  = quad_reg;
        timer_next = timer_reg;
        lstr_next  = lstr_reg;
        lcnt_next  = lcnt_reg;
        rstr_next  = rstr_reg;
        rcnt_next  = rcnt_reg;
        res.pressed  = '0;
        res.released = '0;

        // rumble loads apply even when the pad is away
        if (item.set_left_rumble)
        begin
            lstr_next = item.left_amount;
            lcnt_next = item.left_ticks;
        end
        if (item.set_right_rumble)
        begin
            rstr_next = item.right_amount;
            rcnt_next = item.right_ticks;
        end

        quad_t0  = quad_reg;
        timer_t0 = timer_reg;

        if (conn)
        begin
            res.pressed[USED_BITS-1:0]  = btn & ~held_reg;
            res.released[USED_BITS-1:0] = held_reg & ~btn;
            held_next = btn;

            // stick in the first quadrant restarts the gesture
            if (lx_pos && ly_pos)
            begin
                quad_t0  = QUAD_FIRST;
                timer_t0 = rotation_timeout;
            end
            if (timer_t0 != '0)
            begin
                timer_next = timer_t0 - 1'b1;
                quad_next  = quad_t0;
                if (quad_next == QUAD_LAST)
                    quad_next = QUAD_FIRST;
                if (lx_pos && !ly_pos && quad_next == QUAD_FIRST)
                    quad_next = QUAD_SECOND;
                if (!lx_pos && ly_neg && quad_next == QUAD_SECOND)
                    quad_next = QUAD_THIRD;
                if (lx_neg && !ly_neg && quad_next == QUAD_THIRD)
                    quad_next = QUAD_LAST;
            end
            else
            begin
                timer_next = timer_t0;
                quad_next  = QUAD_FIRST;
            end

            if (lcnt_next != '0)
                lcnt_next = lcnt_next - 1'b1;
            else
                lstr_next = '0;
            if (rcnt_next != '0)
                rcnt_next = rcnt_next - 1'b1;
            else
                rstr_next = '0;
        end

        res.rotation_done = (quad_next == QUAD_LAST);
        res.left_motor    = lstr_next;
        res.right_motor   = rstr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            quad_reg  <= QUAD_FIRST;
            timer_reg <= '0;
            lstr_reg  <= '0;
            lcnt_reg  <= '0;
            rstr_reg  <= '0;
            rcnt_reg  <= '0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            quad_reg  <= quad_next;
            timer_reg <= timer_next;
            lstr_reg  <= lstr_next;
            lcnt_reg  <= lcnt_next;
            rstr_reg  <= rstr_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    // an expired gesture with the stick outside the first quadrant falls back to first
    `GIC_ASSERT_NXT(a_expired_first, clk, rst_n, accept && conn && timer_reg == '0 && !(lx_pos && ly_pos), quad_reg == QUAD_FIRST)

endmodule
`default_nettype wire

// ===== rtl/gamepad_input_conditioner_unit.sv =====
// Top level of the gamepad input conditioner: config, filter lanes, control, output buffer.
//
// Each input transaction is one poll tick of a gamepad and yields exactly one result
// transaction. The tick is fully processed in the cycle it is accepted: four filter lanes
// (one per stick axis, each a 25x17 signed multiply plus round and add in its own state
// feedback loop) run beside the button/gesture/rumble control, and a merge stage packs
// their outputs into the result. Throughput is one tick per clock while in.ready is high; the
// result is registered on acceptance and passes through a two-entry output
// buffer, so in.ready stays high while one finished result waits, and drops only when two
// results are waiting. The per-lane multiply-add loop sets the clock limit. Configuration
// (filter_alpha at index 0, rotation_timeout at index 1) is written through cfg_we,
// cfg_index and cfg_wdata and should only change while no tick is in flight. Reset
// returns all state to zero, the gesture to the first quadrant and the registers to
// alpha = 9362, timeout = 60; no clearing pass is needed.
`default_nettype none
`include "gamepad_input_conditioner_unit_macros.svh"
module gamepad_input_conditioner_unit #(
    parameter int BUTTON_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [gic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gic_pkg::CFG_DATA_W-1:0] cfg_wdata,
    gic_in_if.sink                              in_ch,
    gic_out_if.source                           out_ch
);
    import gic_pkg::*;

    // configuration registers
    logic [ALPHA_W-1:0] alpha_reg;
    logic [TIMER_W-1:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= ALPHA_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_ALPHA:     alpha_reg   <= cfg_wdata[ALPHA_W-1:0];
                CFG_ROTATION_TIMEOUT: timeout_reg <= cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: accept whenever the skid entry is free
    logic  push;
    logic  pop;
    logic  skid_valid_reg;
    logic  main_valid_reg;
    item_t item;

    assign item        = in_ch.data;
    assign in_ch.ready = !skid_valid_reg;
    assign push        = in_ch.valid && !skid_valid_reg;
    assign pop         = main_valid_reg && out_ch.ready;

    // filter lanes, one per axis (LX, LY, RX, RY)
    logic signed [AXIS_W-1:0] lane_in  [NUM_AXES];
    logic signed [AXIS_W-1:0] lane_out [NUM_AXES];
    logic                     filt_step;

    assign lane_in[0] = item.left_x;
    assign lane_in[1] = item.left_y;
    assign lane_in[2] = item.right_x;
    assign lane_in[3] = item.right_y;
    assign filt_step  = push && item.connected;

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_lane
        gic_axis_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .step   (filt_step),
            .alpha  (alpha_reg),
            .sample (lane_in[i]),
            .smooth (lane_out[i])
        );
    end

    // buttons, gesture and rumble
    ctrl_res_t ctrl_res;

    gic_tick_ctrl #(
        .BUTTON_BITS (BUTTON_BITS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (push),
        .item             (item),
        .rotation_timeout (timeout_reg),
        .res              (ctrl_res)
    );

    // merge stage: pack lanes and control into one result
    result_t res_new;

    always_comb
    begin
        res_new.buttons_pressed  = ctrl_res.pressed;
        res_new.buttons_released = ctrl_res.released;
        res_new.smooth_left_x    = lane_out[0];
        res_new.smooth_left_y    = lane_out[1];
        res_new.smooth_right_x   = lane_out[2];
        res_new.smooth_right_y   = lane_out[3];
        res_new.rotation_done    = ctrl_res.rotation_done;
        res_new.left_motor       = ctrl_res.left_motor;
        res_new.right_motor      = ctrl_res.right_motor;
        res_new.link_up          = item.connected;
    end

    // two-entry output buffer: main drives the port, skid catches one more result
    result_t main_reg;
    result_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                skid_reg <= res_new;
            end
            else
            begin
                main_reg <= res_new;
            end
        end
        else if (push)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_ch.valid = main_valid_reg;
    assign out_ch.data  = main_reg;

    // skid entry only fills behind a waiting main entry
    `GIC_ASSERT_IMP(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg)
    // a new transaction against a stalled main entry lands in the skid entry
    `GIC_ASSERT_NXT(a_push_to_skid, clk, rst_n, push && main_valid_reg && !pop, skid_valid_reg)
    // taking the last result with nothing new empties the buffer
    `GIC_ASSERT_NXT(a_drain_empty, clk, rst_n, pop && !skid_valid_reg && !push, !main_valid_reg)

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the gamepad input conditioner: directed ticks, then random traffic.
module testbench;
    import gic_pkg::*;

    // Hard stop in clock cycles. A slow correct run needs far fewer than this.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 10;

    // How the left stick is aimed for one tick.
    typedef enum int {
        AIM_POS,
        AIM_NEG,
        AIM_ZERO_OR_POS,
        AIM_ZERO_OR_NEG,
        AIM_ANY
    } aim_t;

    bit   clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gic_in_if  in_ch ();
    gic_out_if out_ch ();

    gamepad_input_conditioner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Idle rates in percent: gaps on the tick side, stalls on the result side.
    int unsigned send_gap_pct;
    int unsigned accept_stall_pct;

    int unsigned mismatch_count;
    int unsigned report_count;
    int unsigned cycle_count;
    logic [BTN_W-1:0] last_buttons;

    // Reports the block owes us, oldest first.
    result_t due_reports[$];

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the conditioner and its registers.
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]       model_alpha;
    logic [TIMER_W-1:0]       model_timeout;
    logic [BTN_W-1:0]         held_q;
    logic signed [FILT_W-1:0] smooth_q [NUM_AXES];
    quad_t                    quad_q;
    logic [TIMER_W-1:0]       gesture_left_q;
    logic [AMT_W-1:0]         left_str_q;
    logic [TIMER_W-1:0]       left_cnt_q;
    logic [AMT_W-1:0]         right_str_q;
    logic [TIMER_W-1:0]       right_cnt_q;

    task automatic reset_model();
        model_alpha    = ALPHA_RESET;
        model_timeout  = TIMEOUT_RESET;
        held_q         = '0;
        for (int i = 0; i < NUM_AXES; i++)
            smooth_q[i] = '0;
        quad_q         = QUAD_FIRST;
        gesture_left_q = '0;
        left_str_q     = '0;
        left_cnt_q     = '0;
        right_str_q    = '0;
        right_cnt_q    = '0;
    endtask

    // f += floor((d * alpha + half) / 2^16), d = x*256 - f, all on the 16.8 state.
    function automatic logic signed [FILT_W-1:0] lowpass(logic signed [FILT_W-1:0] state,
                                                         logic signed [AXIS_W-1:0] sample);
        longint diff;
        longint prod;
        diff = 256 * longint'(sample) - longint'(state);
        prod = diff * longint'({1'b0, model_alpha}) + 32768;
        return FILT_W'(longint'(state) + (prod >>> 16));
    endfunction

    // Advances the predictor by one accepted tick and returns the report it must produce.
    function automatic result_t condition_tick(item_t tick);
        result_t                  rep;
        logic signed [AXIS_W-1:0] raw [NUM_AXES];
        logic signed [AXIS_W-1:0] lx;
        logic signed [AXIS_W-1:0] ly;
        raw[0] = tick.left_x;
        raw[1] = tick.left_y;
        raw[2] = tick.right_x;
        raw[3] = tick.right_y;
        lx = tick.left_x;
        ly = tick.left_y;
        rep = '0;

        // Rumble loads land before the tick's update, connected or not.
        if (tick.set_left_rumble)
        begin
            left_str_q = tick.left_amount;
            left_cnt_q = tick.left_ticks;
        end
        if (tick.set_right_rumble)
        begin
            right_str_q = tick.right_amount;
            right_cnt_q = tick.right_ticks;
        end

        if (tick.connected)
        begin
            rep.buttons_pressed  = tick.buttons & ~held_q;
            rep.buttons_released = held_q & ~tick.buttons;
            held_q = tick.buttons;

            for (int i = 0; i < NUM_AXES; i++)
                smooth_q[i] = lowpass(smooth_q[i], raw[i]);

            // Stick in the first quadrant restarts the gesture and its budget.
            if (lx > 0 && ly > 0)
            begin
                quad_q         = QUAD_FIRST;
                gesture_left_q = model_timeout;
            end
            if (gesture_left_q != 0)
            begin
                gesture_left_q = gesture_left_q - 1'b1;
                if (quad_q == QUAD_LAST)
                    quad_q = QUAD_FIRST;
                if (lx > 0 && ly <= 0 && quad_q == QUAD_FIRST)
                    quad_q = QUAD_SECOND;
                if (lx <= 0 && ly < 0 && quad_q == QUAD_SECOND)
                    quad_q = QUAD_THIRD;
                if (lx < 0 && ly >= 0 && quad_q == QUAD_THIRD)
                    quad_q = QUAD_LAST;
            end
            else
                quad_q = QUAD_FIRST;

            if (left_cnt_q != 0)
                left_cnt_q = left_cnt_q - 1'b1;
            else
                left_str_q = '0;
            if (right_cnt_q != 0)
                right_cnt_q = right_cnt_q - 1'b1;
            else
                right_str_q = '0;
        end

        rep.smooth_left_x  = smooth_q[0][FILT_W-1:FRAC_W];
        rep.smooth_left_y  = smooth_q[1][FILT_W-1:FRAC_W];
        rep.smooth_right_x = smooth_q[2][FILT_W-1:FRAC_W];
        rep.smooth_right_y = smooth_q[3][FILT_W-1:FRAC_W];
        rep.rotation_done  = (quad_q == QUAD_LAST);
        rep.left_motor     = left_str_q;
        rep.right_motor    = right_str_q;
        rep.link_up        = tick.connected;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Clock and result-side stalls.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= accept_stall_pct);

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, due_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("report %0d: %s expected %h, got %h", report_count, field, want, got);
        end
    endfunction

    // Scoreboard. Ticks are predicted as they are accepted; results are sampled
    // on the same edge and compared with the oldest outstanding report.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                due_reports.push_back(condition_tick(in_ch.data));
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("report %0d arrived with no tick outstanding", report_count);
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("buttons_pressed", want.buttons_pressed,
                                out_ch.data.buttons_pressed);
                    check_field("buttons_released", want.buttons_released,
                                out_ch.data.buttons_released);
                    check_field("smooth_left_x", want.smooth_left_x, out_ch.data.smooth_left_x);
                    check_field("smooth_left_y", want.smooth_left_y, out_ch.data.smooth_left_y);
                    check_field("smooth_right_x", want.smooth_right_x,
                                out_ch.data.smooth_right_x);
                    check_field("smooth_right_y", want.smooth_right_y,
                                out_ch.data.smooth_right_y);
                    check_field("rotation_done", want.rotation_done, out_ch.data.rotation_done);
                    check_field("left_motor", want.left_motor, out_ch.data.left_motor);
                    check_field("right_motor", want.right_motor, out_ch.data.right_motor);
                    check_field("link_up", want.link_up, out_ch.data.link_up);
                end
                report_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Everything below is entered and left on a falling edge.
    // ------------------------------------------------------------------

    // Presents one tick; valid stays high into the next call unless a gap is drawn.
    task automatic send_tick(item_t tick);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= tick;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every outstanding report has come back.
    task automatic wait_for_reports();
        in_ch.valid <= 1'b0;
        while (due_reports.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FILTER_ALPHA)
            model_alpha = value;
        else if (idx == CFG_ROTATION_TIMEOUT)
            model_timeout = value;
    endtask

    // ------------------------------------------------------------------
    // Tick builders.
    // ------------------------------------------------------------------
    function automatic item_t quiet_tick();
        item_t tick;
        tick = '0;
        tick.connected = 1'b1;
        return tick;
    endfunction

    function automatic logic signed [AXIS_W-1:0] axis_sample(aim_t aim);
        int unsigned pick;
        pick = $urandom_range(99);
        case (aim)
            AIM_POS:
                return (pick < 5) ? 16'sd32767 : (pick < 10) ? 16'sd1
                                                             : AXIS_W'($urandom_range(32767, 1));
            AIM_NEG:
                return (pick < 5) ? -16'sd32768 : (pick < 10) ? -16'sd1
                                                              : AXIS_W'(-int'($urandom_range(32768, 1)));
            AIM_ZERO_OR_POS:
                return (pick < 15) ? 16'sd0 : axis_sample(AIM_POS);
            AIM_ZERO_OR_NEG:
                return (pick < 15) ? 16'sd0 : axis_sample(AIM_NEG);
            default:
                return (pick < 4) ? 16'sd32767 : (pick < 8) ? -16'sd32768
                                  : (pick < 11) ? 16'sd0 : AXIS_W'($urandom);
        endcase
    endfunction

    // Random tick; when aimed, the left stick sits in quadrant q.
    function automatic item_t random_tick(bit aimed, quad_t q);
        item_t       tick;
        int unsigned pick;
        tick.connected = ($urandom_range(99) >= 6);

        // Buttons mostly change a bit or two, as a player would; sometimes jump.
        pick = $urandom_range(99);
        if (pick < 55)
            last_buttons = last_buttons ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
        else if (pick < 65)
            last_buttons = ($urandom_range(1)) ? '1 : '0;
        else if (pick < 90)
            last_buttons = BTN_W'($urandom);
        tick.buttons = last_buttons;

        if (!aimed)
        begin
            tick.left_x = axis_sample(AIM_ANY);
            tick.left_y = axis_sample(AIM_ANY);
        end
        else
        begin
            case (q)
                QUAD_FIRST:
                begin
                    tick.left_x = axis_sample(AIM_POS);
                    tick.left_y = axis_sample(AIM_POS);
                end
                QUAD_SECOND:
                begin
                    tick.left_x = axis_sample(AIM_POS);
                    tick.left_y = axis_sample(AIM_ZERO_OR_NEG);
                end
                QUAD_THIRD:
                begin
                    tick.left_x = axis_sample(AIM_ZERO_OR_NEG);
                    tick.left_y = axis_sample(AIM_NEG);
                end
                default:
                begin
                    tick.left_x = axis_sample(AIM_NEG);
                    tick.left_y = axis_sample(AIM_ZERO_OR_POS);
                end
            endcase
        end
        tick.right_x = axis_sample(AIM_ANY);
        tick.right_y = axis_sample(AIM_ANY);

        // Amount and ticks carry junk when not loaded; they must be ignored then.
        tick.set_left_rumble  = ($urandom_range(99) < 8);
        tick.left_amount      = AMT_W'($urandom);
        tick.left_ticks       = ($urandom_range(99) < 80) ? TIMER_W'($urandom_range(30))
                                                          : TIMER_W'($urandom);
        tick.set_right_rumble = ($urandom_range(99) < 8);
        tick.right_amount     = AMT_W'($urandom);
        tick.right_ticks      = ($urandom_range(99) < 80) ? TIMER_W'($urandom_range(30))
                                                          : TIMER_W'($urandom);
        return tick;
    endfunction

    // Mostly clockwise rotations with random dwell per quarter; some are broken by a
    // stray sample in one quarter, and the rest is free-running noise.
    task automatic run_traffic(int unsigned tx_gap, int unsigned rx_stall, int unsigned count);
        int unsigned sent;
        int unsigned broken_step;
        quad_t       q;
        send_gap_pct     = tx_gap;
        accept_stall_pct = rx_stall;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 65)
            begin
                broken_step = ($urandom_range(99) < 15) ? $urandom_range(3) : 4;
                for (int step = 0; step < 4; step++)
                begin
                    q = quad_t'(step);
                    repeat ($urandom_range(3, 1))
                    begin
                        send_tick(random_tick(step != broken_step, q));
                        sent++;
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                begin
                    send_tick(random_tick(1'b0, QUAD_FIRST));
                    sent++;
                end
            end
        end
        wait_for_reports();
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------
    task automatic test_button_edges();
        item_t tick;
        tick = quiet_tick();
        send_tick(tick);
        tick.buttons = 16'hFFFF;   // every button pressed at once
        send_tick(tick);
        tick.buttons = 16'h0000;   // every button released at once
        send_tick(tick);
        tick.buttons = 16'hAAAA;
        send_tick(tick);
        tick.buttons = 16'h5555;   // half press while the other half releases
        send_tick(tick);
    endtask

    task automatic test_axis_extremes();
        item_t tick;
        tick = quiet_tick();
        tick.left_x  = 16'sh7FFF;
        tick.left_y  = 16'sh7FFF;
        tick.right_x = 16'sh7FFF;
        tick.right_y = 16'sh7FFF;
        send_tick(tick);
        tick.left_x  = -16'sh8000;
        tick.left_y  = -16'sh8000;
        tick.right_x = -16'sh8000;
        tick.right_y = -16'sh8000;
        send_tick(tick);
        tick.left_x  = 16'sh7FFF;
        tick.right_y = 16'sh7FFF;
        send_tick(tick);
    endtask

    // One clean clockwise turn, quarter boundaries on the zero axis lines.
    task automatic test_rotation();
        item_t tick;
        tick = quiet_tick();
        tick.left_x = 16'sd1000;
        tick.left_y = 16'sd1000;
        send_tick(tick);
        tick.left_y = 16'sd0;
        send_tick(tick);
        tick.left_x = 16'sd0;
        tick.left_y = -16'sd1000;
        send_tick(tick);
        tick.left_x = -16'sd1000;
        tick.left_y = 16'sd0;        // done flag should rise here
        send_tick(tick);
        tick.left_y = 16'sd500;      // last quarter falls back to first
        send_tick(tick);
    endtask

    task automatic test_rumble();
        item_t tick;
        tick = quiet_tick();
        // Left loads two ticks; right loads zero ticks and clears in the same tick.
        tick.set_left_rumble  = 1'b1;
        tick.left_amount      = 8'hFF;
        tick.left_ticks       = 16'd2;
        tick.set_right_rumble = 1'b1;
        tick.right_amount     = 8'hFF;
        tick.right_ticks      = 16'd0;
        send_tick(tick);
        // Loads still land while the pad is gone, but nothing counts down.
        tick.connected        = 1'b0;
        tick.left_amount      = 8'h01;
        tick.left_ticks       = 16'hFFFF;
        tick.right_amount     = 8'h80;
        tick.right_ticks      = 16'd3;
        send_tick(tick);
        tick = quiet_tick();
        repeat (3) send_tick(tick);
    endtask

    task automatic test_disconnected();
        item_t tick;
        tick = quiet_tick();
        tick.connected = 1'b0;
        tick.buttons   = 16'hFFFF;   // no edges while the link is down
        tick.left_x    = 16'sd2000;
        tick.left_y    = 16'sd2000;
        tick.right_x   = -16'sh8000;
        send_tick(tick);
        send_tick(tick);
        tick.connected = 1'b1;       // edges show up once it is back
        send_tick(tick);
    endtask

    // ------------------------------------------------------------------
    // Random tests under different register settings.
    // ------------------------------------------------------------------
    task automatic test_reset_settings();
        run_traffic(13, 78, 300);
    endtask

    // Filter follows the input almost at once; a one-tick budget blocks every gesture.
    task automatic test_fast_filter_short_timeout();
        write_reg(CFG_FILTER_ALPHA, 16'hFFFF);
        write_reg(CFG_ROTATION_TIMEOUT, 16'd1);
        run_traffic(78, 13, 300);
    endtask

    // Frozen filter and a budget that never runs out.
    task automatic test_frozen_filter_long_timeout();
        write_reg(CFG_FILTER_ALPHA, 16'h0000);
        write_reg(CFG_ROTATION_TIMEOUT, 16'hFFFF);
        run_traffic(0, 0, 250);
    endtask

    // Random coefficient, budgets short enough that gestures often time out.
    task automatic test_random_settings();
        write_reg(CFG_FILTER_ALPHA, CFG_DATA_W'($urandom));
        write_reg(CFG_ROTATION_TIMEOUT, CFG_DATA_W'($urandom_range(12, 2)));
        run_traffic(13, 78, 350);
        write_reg(CFG_FILTER_ALPHA, CFG_DATA_W'($urandom));
        write_reg(CFG_ROTATION_TIMEOUT, CFG_DATA_W'($urandom_range(40, 3)));
        run_traffic(78, 13, 350);
    endtask

    task automatic test_restored_settings();
        write_reg(CFG_FILTER_ALPHA, ALPHA_RESET);
        write_reg(CFG_ROTATION_TIMEOUT, TIMEOUT_RESET);
        run_traffic(0, 0, 300);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        out_ch.ready     = 1'b0;
        send_gap_pct     = 13;
        accept_stall_pct = 78;
        mismatch_count   = 0;
        report_count     = 0;
        cycle_count      = 0;
        last_buttons     = '0;
        reset_model();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_button_edges();
        test_axis_extremes();
        test_rotation();
        test_rumble();
        test_disconnected();
        wait_for_reports();

        test_reset_settings();
        test_fast_filter_short_timeout();
        test_frozen_filter_long_timeout();
        test_random_settings();
        test_restored_settings();

        // Nothing should trickle out after the last report.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_reports.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gic_pkg.sv
rtl/gic_if.sv
rtl/gic_axis_lane.sv
rtl/gic_tick_ctrl.sv
rtl/gamepad_input_conditioner_unit.sv
dv/testbench.sv
